// ===== rtl/ped_pkg.sv =====
// shared types, widths and constants of the quintic evaluator
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ped_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned TIME_W        = 24;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned SCOEF_W       = 38;
  localparam int unsigned ACC_W         = 48;
  localparam int unsigned NUM_LANES     = 4;
  localparam int unsigned NUM_COEF      = 6;
  localparam int unsigned NUM_STEPS     = NUM_COEF - 1;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned OUT_DEPTH     = 32;

  typedef logic        [TIME_W-1:0]  time_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [SCOEF_W-1:0] scoef_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef acc_t   [NUM_LANES-1:0] lane_vec_t;
  typedef scoef_t [NUM_LANES-1:0] coef_vec_t;

  typedef struct packed {
    logic      vld;
    time_t     t;
    lane_vec_t acc;
  } beat_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // k! / (k-d)!, zero where the term drops out of the d-th derivative
  function automatic int unsigned deriv_scale(input int unsigned d, input int unsigned k);
    int unsigned f;
    f = 1;
    if (k < d) begin
      f = 0;
    end else begin
      for (int unsigned i = 0; i < d; i++) begin
        f = f * (k - i);
      end
    end
    return f;
  endfunction

  function automatic scoef_t scale_coef(input coef_t c, input int unsigned d,
                                        input int unsigned k);
    logic signed [7:0] f;
    f = 8'(deriv_scale(d, k));
    return scoef_t'(c) * scoef_t'(f);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ped_cell.sv =====
// one horner step for all four lanes: acc = sat(floor(acc * t / 2^frac) + c)
// three register stages: partial products, shift and clamp, coefficient add
// depends on ped_pkg
`timescale 1ns / 1ps
`default_nettype none

module ped_cell #(
  parameter int unsigned FRAC_BITS = ped_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ped_pkg::beat_t    beat_i,
  input  wire ped_pkg::coef_vec_t coef_i,
  output ped_pkg::beat_t         beat_o
);
  import ped_pkg::*;

  localparam int unsigned HALF_W = ACC_W / 2;
  localparam int unsigned HI_W   = ACC_W - HALF_W;
  localparam int unsigned PHI_W  = HI_W + TIME_W + 1;
  localparam int unsigned PLO_W  = HALF_W + TIME_W;
  localparam int unsigned PROD_W = ACC_W + TIME_W + 1;
  localparam int unsigned SUM_W  = ACC_W + 1;

  // stage 1
  logic                    v1_q;
  time_t                   t1_q;
  logic signed [PHI_W-1:0] phi_d [NUM_LANES];
  logic signed [PHI_W-1:0] phi_q [NUM_LANES];
  logic        [PLO_W-1:0] plo_d [NUM_LANES];
  logic        [PLO_W-1:0] plo_q [NUM_LANES];

  // stage 2
  logic  v2_q;
  time_t t2_q;
  acc_t  prd_d [NUM_LANES];
  acc_t  prd_q [NUM_LANES];

  // stage 3
  logic      v3_q;
  time_t     t3_q;
  lane_vec_t acc_d;
  lane_vec_t acc_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      phi_d[l] = PHI_W'($signed(beat_i.acc[l][ACC_W-1:HALF_W]) *
                        $signed({1'b0, beat_i.t}));
      plo_d[l] = PLO_W'(beat_i.acc[l][HALF_W-1:0] * beat_i.t);
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shf;
    for (int l = 0; l < NUM_LANES; l++) begin
      prod = $signed({phi_q[l], {HALF_W{1'b0}}}) +
             $signed({{(PROD_W-PLO_W){1'b0}}, plo_q[l]});
      shf  = prod >>> FRAC_BITS;
      if ((&shf[PROD_W-1:ACC_W-1]) || !(|shf[PROD_W-1:ACC_W-1])) begin
        prd_d[l] = shf[ACC_W-1:0];
      end else if (shf[PROD_W-1]) begin
        prd_d[l] = ACC_MIN;
      end else begin
        prd_d[l] = ACC_MAX;
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int l = 0; l < NUM_LANES; l++) begin
      sum = $signed({prd_q[l][ACC_W-1], prd_q[l]}) +
            $signed({{(SUM_W-SCOEF_W){coef_i[l][SCOEF_W-1]}}, coef_i[l]});
      if (sum[SUM_W-1] == sum[SUM_W-2]) begin
        acc_d[l] = sum[ACC_W-1:0];
      end else if (sum[SUM_W-1]) begin
        acc_d[l] = ACC_MIN;
      end else begin
        acc_d[l] = ACC_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= beat_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= beat_i.t;
    phi_q <= phi_d;
    plo_q <= plo_d;
    t2_q  <= t1_q;
    prd_q <= prd_d;
    t3_q  <= t2_q;
    acc_q <= acc_d;
  end

  assign beat_o.vld = v3_q;
  assign beat_o.t   = t3_q;
  assign beat_o.acc = acc_q;

endmodule

`default_nettype wire

// ===== rtl/ped_out_fifo.sv =====
// result queue between the cell chain and the output channel
// depends on ped_pkg
`timescale 1ns / 1ps
`default_nettype none

module ped_out_fifo #(
  parameter int unsigned DEPTH = ped_pkg::OUT_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ped_pkg::lane_vec_t push_data_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output ped_pkg::lane_vec_t      data_o
);
  import ped_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lane_vec_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/poly_eval_with_derivatives.sv =====
// quintic trajectory evaluator: position and first three derivatives per time item
// top level; depends on ped_pkg, ped_cell, ped_out_fifo
//
// usage:
//   cfg channel (cfg_valid_i / cfg_ready_o, always ready) writes coeff_0..coeff_5
//   by cfg_index_i; indexes above 5 are dropped. write only while the block is idle.
//   input channel: time_in_i taken when in_valid_i is high and in_stall_o is low.
//   output channel: one item of position, velocity, acceleration and jerk,
//   taken when out_valid_o is high and out_stall_i is low.
// throughput: one item per cycle while in_stall_o is low. five horner cells of
//   three register stages each (multiply, shift/clamp, add/clamp) feed a 32-entry
//   result queue.
// stall: the queue keeps results while out_stall_i is high; input stays open until
//   32 items are outstanding, then in_stall_o rises until a result is taken.
// reset: coefficients return to zero, the cell chain and the queue are emptied.
`timescale 1ns / 1ps
`default_nettype none

module poly_eval_with_derivatives #(
  parameter int unsigned FRAC_BITS = ped_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ped_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire ped_pkg::coef_t                cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire ped_pkg::time_t                time_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ped_pkg::acc_t                      position_o,
  output ped_pkg::acc_t                      velocity_o,
  output ped_pkg::acc_t                      acceleration_o,
  output ped_pkg::acc_t                      jerk_o
);
  import ped_pkg::*;

  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

  scoef_t    scoef_q [NUM_LANES][NUM_COEF];
  beat_t     chain [NUM_STEPS+1];
  lane_vec_t init_acc;
  lane_vec_t res;
  logic      in_acc, out_acc;
  logic [CW-1:0] cnt_q, cnt_d;

  assign cfg_ready_o = 1'b1;

  // derivative coefficients, scaled when written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_LANES; d++) begin
        for (int k = 0; k < NUM_COEF; k++) begin
          scoef_q[d][k] <= '0;
        end
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      for (int d = 0; d < NUM_LANES; d++) begin
        for (int k = 0; k < NUM_COEF; k++) begin
          if (cfg_index_i == CFG_IDX_W'(k)) begin
            scoef_q[d][k] <= scale_coef(cfg_data_i, d, k);
          end
        end
      end
    end
  end

  // outstanding item count
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign in_stall_o = (cnt_q == CW'(OUT_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // leading coefficient for the position lane; higher derivatives start from zero
  always_comb begin
    for (int d = 0; d < NUM_LANES; d++) begin
      init_acc[d] = '0;
    end
    init_acc[0] = ACC_W'(scoef_q[0][NUM_COEF-1]);
  end

  assign chain[0].vld = in_acc;
  assign chain[0].t   = time_in_i;
  assign chain[0].acc = init_acc;

  for (genvar n = 0; n < NUM_STEPS; n++) begin : g_cell
    coef_vec_t cv;
    for (genvar d = 0; d < NUM_LANES; d++) begin : g_lane
      if (NUM_STEPS - 1 - n + d < NUM_COEF) begin : g_used
        assign cv[d] = scoef_q[d][NUM_STEPS-1-n+d];
      end else begin : g_pad
        assign cv[d] = '0;
      end
    end

    ped_cell #(
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .beat_i(chain[n]),
      .coef_i(cv),
      .beat_o(chain[n+1])
    );
  end

  ped_out_fifo #(
    .DEPTH(OUT_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (chain[NUM_STEPS].vld),
    .push_data_i(chain[NUM_STEPS].acc),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .data_o     (res)
  );

  assign position_o     = res[0];
  assign velocity_o     = res[1];
  assign acceleration_o = res[2];
  assign jerk_o         = res[3];

endmodule

`default_nettype wire

// ===== rtl/ped_checker.sv =====
// port-level checks of the quintic evaluator, bound to the top level
// depends on ped_pkg and poly_eval_with_derivatives
`timescale 1ns / 1ps
`default_nettype none

module ped_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire ped_pkg::acc_t position_o,
  input wire ped_pkg::acc_t velocity_o,
  input wire ped_pkg::acc_t acceleration_o,
  input wire ped_pkg::acc_t jerk_o
);

  // input backpressure only builds up behind a stalled result
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without a stalled result");

  // input backpressure only clears after a result is taken
  a_stall_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(out_valid_o && !out_stall_i))
    else $error("input stall fell without a delivered result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(position_o) && $stable(velocity_o) &&
      $stable(acceleration_o) && $stable(jerk_o))
    else $error("result changed while stalled");

endmodule

bind poly_eval_with_derivatives ped_checker u_ped_checker (.*);

`default_nettype wire
